// File: rtl/assert_macros.svh
// Assertion macros used by the checker file.
// Included by bare file name; no other dependencies.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, disabled while reset is asserted
`define ASSERT_IMP(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("same-cycle implication failed");

// next-cycle implication, disabled while reset is asserted
`define ASSERT_NXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("next-cycle implication failed");

`endif

// File: rtl/ipsp_pkg.sv
// Package for the IP stride L2 prefetcher: sizes, class codes, table types,
// sequencer states and small helper functions. No dependencies.
`default_nettype none

package ipsp_pkg;

  localparam int INDEX_BITS       = 6;
  localparam int TAG_BITS         = 9;
  localparam int LINE_OFFSET_BITS = 6;
  localparam int PAGE_OFFSET_BITS = 12;
  localparam int ADDR_BITS        = 48;

  localparam int ENTRIES        = 1 << INDEX_BITS;
  localparam int LINE_BITS      = ADDR_BITS - LINE_OFFSET_BITS;
  localparam int PAGE_LINE_BITS = PAGE_OFFSET_BITS - LINE_OFFSET_BITS;

  localparam int IP_W    = 15;
  localparam int META_W  = 13;
  localparam int CLS_W   = 4;
  localparam int STR_W   = 7;
  localparam int MAG_W   = 6;
  localparam int DEG_W   = 3;
  localparam int CNT_W   = 4;
  localparam int IPX_W   = IP_W + INDEX_BITS + TAG_BITS;

  localparam int META_CLS_LSB = 8;
  localparam int META_SPEC    = 12;
  localparam int STR_SIGN     = 6;

  localparam int APB_ADDR_W = 3;
  localparam int APB_DATA_W = 32;

  localparam logic REG_BASE_DEGREE = 1'b0;

  localparam logic [CLS_W-1:0] CLS_STREAM = 4'd1;
  localparam logic [CLS_W-1:0] CLS_CONST  = 4'd2;
  localparam logic [CLS_W-1:0] CLS_SPEC   = 4'd3;
  localparam logic [CLS_W-1:0] CLS_NEXT   = 4'd4;

  localparam logic [DEG_W-1:0] DEG_MAX   = 3'd4;
  localparam logic [DEG_W-1:0] DEG_RESET = 3'd3;

  typedef logic [LINE_BITS-1:0] line_t;

  typedef struct packed {
    logic [TAG_BITS-1:0] tag;
    logic [CLS_W-1:0]    cls;
    logic [STR_W-1:0]    stride;
  } entry_t;

  typedef struct packed {
    logic                  rd_en;
    logic [INDEX_BITS-1:0] rd_idx;
    logic                  wr_en;
    logic [INDEX_BITS-1:0] wr_idx;
    logic                  wr_valid;
    entry_t                wr_entry;
  } tbl_req_t;

  typedef struct packed {
    logic   valid;
    entry_t entry;
  } tbl_rsp_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_LOOKUP,
    ST_STRIDE,
    ST_NEXT,
    ST_FINISH
  } state_e;

  function automatic logic [TAG_BITS-1:0] ip_tag(input logic [IP_W-1:0] ip);
    logic [IPX_W-1:0] ipx;
    ipx = IPX_W'(ip);
    return ipx[INDEX_BITS +: TAG_BITS];
  endfunction

  function automatic logic [META_W-1:0] fill_meta(input logic [CLS_W-1:0] cls,
                                                  input logic spec);
    return {spec, cls, 7'd0, 1'b1};
  endfunction

endpackage

`default_nettype wire

// File: rtl/ip_stride_l2_prefetcher_core.sv
// Top level of the IP stride L2 prefetcher: APB register, IP table, sequencer.
// Depends on ipsp_pkg, ipsp_table, ipsp_ctrl.
//
// Usage:
//   An access transfer is taken at a rising edge with start high and busy low.
//   The access looks up a 64-entry direct-mapped table by its IP bits, then a
//   sequencer steps one shared line adder to produce prefetch line addresses.
//   Each prefetch shows on the result ports for one cycle with
//   prefetch_valid_o high; last_flag_o marks the final one of the access.
//   Results of a stride run come one per cycle in ST_STRIDE and ST_FINISH,
//   with a gap before the last when the page cuts the run short; a plain
//   next line, or the next-line fallback after a stride leaves the page at
//   once, shows in ST_FINISH. busy stays high through the table read, one
//   adder step per prefetch and the table write.
//   The receiver cannot stall: every result strobe is one transfer.
//   base_degree lives at APB addresses 0 to 3 (paddr[2] low; reset value 3);
//   write it only while busy is low. Reset clears the speculative bit and, at
//   once through per-entry valid flags, the table; no clearing pass is needed.
`default_nettype none

module ip_stride_l2_prefetcher_core (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 psel,
  input  logic                                 penable,
  input  logic                                 pwrite,
  input  logic [ipsp_pkg::APB_ADDR_W-1:0]      paddr,
  input  logic [ipsp_pkg::APB_DATA_W-1:0]      pwdata,
  output logic [ipsp_pkg::APB_DATA_W-1:0]      prdata,
  output logic                                 pready,
  input  logic                                 start,
  output logic                                 busy,
  input  logic [ipsp_pkg::ADDR_BITS-1:0]       access_addr_i,
  input  logic [ipsp_pkg::IP_W-1:0]            access_ip_i,
  input  logic                                 is_prefetch_i,
  input  logic [ipsp_pkg::META_W-1:0]          meta_in_i,
  output logic                                 prefetch_valid_o,
  output logic [ipsp_pkg::ADDR_BITS-1:0]       prefetch_addr_o,
  output logic [ipsp_pkg::META_W-1:0]          fill_meta_o,
  output logic                                 last_flag_o
);
  import ipsp_pkg::*;

  logic [DEG_W-1:0] base_degree_q;
  logic             reg_sel;
  tbl_req_t         tbl_req;
  tbl_rsp_t         tbl_rsp;

  assign pready  = 1'b1;
  assign reg_sel = (paddr[APB_ADDR_W-1] == REG_BASE_DEGREE);
  assign prdata  = reg_sel ? APB_DATA_W'(base_degree_q) : '0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      base_degree_q <= DEG_RESET;
    end else if (psel && penable && pwrite && pready && reg_sel) begin
      base_degree_q <= pwdata[DEG_W-1:0];
    end
  end

  ipsp_table u_table (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (tbl_req),
    .rsp_o  (tbl_rsp)
  );

  ipsp_ctrl u_ctrl (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .start            (start),
    .busy             (busy),
    .access_addr_i    (access_addr_i),
    .access_ip_i      (access_ip_i),
    .is_prefetch_i    (is_prefetch_i),
    .meta_in_i        (meta_in_i),
    .base_degree_i    (base_degree_q),
    .tbl_req_o        (tbl_req),
    .tbl_rsp_i        (tbl_rsp),
    .prefetch_valid_o (prefetch_valid_o),
    .prefetch_addr_o  (prefetch_addr_o),
    .fill_meta_o      (fill_meta_o),
    .last_flag_o      (last_flag_o)
  );

endmodule

`default_nettype wire

// File: rtl/ipsp_step_unit.sv
// Shared line-step unit: adds or subtracts a line distance and checks the page.
// Depends on ipsp_pkg.
`default_nettype none

module ipsp_step_unit (
  input  ipsp_pkg::line_t           base_i,
  input  ipsp_pkg::line_t           page_ref_i,
  input  logic [ipsp_pkg::MAG_W-1:0] mag_i,
  input  logic                      neg_i,
  output ipsp_pkg::line_t           cand_o,
  output logic                      in_page_o
);
  import ipsp_pkg::*;

  line_t step_len;

  assign step_len  = LINE_BITS'(mag_i);
  assign cand_o    = neg_i ? (base_i - step_len) : (base_i + step_len);
  assign in_page_o = (cand_o[LINE_BITS-1:PAGE_LINE_BITS] ==
                      page_ref_i[LINE_BITS-1:PAGE_LINE_BITS]);

endmodule

`default_nettype wire

// File: rtl/ipsp_table.sv
// Direct-mapped IP table: entry memory with registered read, written and
// valid bits in flip-flops. Depends on ipsp_pkg.
`default_nettype none

module ipsp_table (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  ipsp_pkg::tbl_req_t req_i,
  output ipsp_pkg::tbl_rsp_t rsp_o
);
  import ipsp_pkg::*;

  entry_t             mem_q [ENTRIES];
  entry_t             rd_q;
  logic [ENTRIES-1:0] written_q;
  logic [ENTRIES-1:0] valid_q;
  logic               rd_written_q;
  logic               rd_valid_q;

  always_ff @(posedge clk_i) begin
    if (req_i.wr_en) begin
      mem_q[req_i.wr_idx] <= req_i.wr_entry;
    end
    if (req_i.rd_en) begin
      rd_q <= mem_q[req_i.rd_idx];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      written_q    <= '0;
      valid_q      <= '0;
      rd_written_q <= 1'b0;
      rd_valid_q   <= 1'b0;
    end else begin
      if (req_i.wr_en) begin
        written_q[req_i.wr_idx] <= 1'b1;
        valid_q[req_i.wr_idx]   <= req_i.wr_valid;
      end
      if (req_i.rd_en) begin
        rd_written_q <= written_q[req_i.rd_idx];
        rd_valid_q   <= valid_q[req_i.rd_idx];
      end
    end
  end

  assign rsp_o.valid = rd_valid_q;
  assign rsp_o.entry = rd_written_q ? rd_q : '0;

endmodule

`default_nettype wire

// File: rtl/ipsp_ctrl.sv
// Sequencer of the prefetcher: table lookup, stride run over the shared step
// unit, next-line fallback and table update. Depends on ipsp_pkg, ipsp_step_unit.
`default_nettype none

module ipsp_ctrl (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               start,
  output logic                               busy,
  input  logic [ipsp_pkg::ADDR_BITS-1:0]     access_addr_i,
  input  logic [ipsp_pkg::IP_W-1:0]          access_ip_i,
  input  logic                               is_prefetch_i,
  input  logic [ipsp_pkg::META_W-1:0]        meta_in_i,
  input  logic [ipsp_pkg::DEG_W-1:0]         base_degree_i,
  output ipsp_pkg::tbl_req_t                 tbl_req_o,
  input  ipsp_pkg::tbl_rsp_t                 tbl_rsp_i,
  output logic                               prefetch_valid_o,
  output logic [ipsp_pkg::ADDR_BITS-1:0]     prefetch_addr_o,
  output logic [ipsp_pkg::META_W-1:0]        fill_meta_o,
  output logic                               last_flag_o
);
  import ipsp_pkg::*;

  state_e                state_q, state_d;
  line_t                 line_q, line_d;
  logic [INDEX_BITS-1:0] idx_q, idx_d;
  logic [TAG_BITS-1:0]   tag_q, tag_d;
  logic                  is_pf_q, is_pf_d;
  logic [CLS_W-1:0]      cls_in_q, cls_in_d;
  logic [STR_W-1:0]      str_in_q, str_in_d;
  logic                  spec_in_q, spec_in_d;
  logic                  spec_q, spec_d;
  entry_t                ent_q, ent_d;
  logic                  ent_valid_q, ent_valid_d;
  line_t                 acc_q, acc_d;
  logic [MAG_W-1:0]      mag_q, mag_d;
  logic                  neg_q, neg_d;
  logic [CNT_W-1:0]      cnt_q, cnt_d;
  logic [CNT_W-1:0]      deg_q, deg_d;
  logic                  pend_v_q, pend_v_d;
  line_t                 pend_line_q, pend_line_d;
  logic [META_W-1:0]     pend_meta_q, pend_meta_d;

  logic                  hit;
  logic [CLS_W-1:0]      eff_cls;
  logic [STR_W-1:0]      eff_str;
  logic                  eff_spec;
  logic [DEG_W-1:0]      deg_lim;
  logic [CNT_W-1:0]      deg_run;
  logic                  stride_ok;
  line_t                 step_base;
  logic [MAG_W-1:0]      step_mag;
  logic                  step_neg;
  line_t                 cand;
  logic                  in_page;

  assign hit      = (tbl_rsp_i.entry.tag == tag_q);
  assign eff_cls  = is_pf_q ? cls_in_q : tbl_rsp_i.entry.cls;
  assign eff_str  = is_pf_q ? str_in_q : tbl_rsp_i.entry.stride;
  assign eff_spec = is_pf_q ? spec_in_q : spec_q;
  assign deg_lim  = (base_degree_i > DEG_MAX) ? DEG_MAX : base_degree_i;
  assign deg_run  = (eff_cls == CLS_STREAM) ? CNT_W'({deg_lim, 1'b0}) : CNT_W'(deg_lim);
  assign stride_ok = hit && ((eff_cls == CLS_STREAM) || (eff_cls == CLS_CONST)) &&
                     (eff_str[MAG_W-1:0] != '0) && (deg_lim != '0);

  always_comb begin
    step_base = line_q;
    step_mag  = MAG_W'(1);
    step_neg  = 1'b0;
    case (state_q)
      ST_LOOKUP: begin
        if (stride_ok) begin
          step_mag = eff_str[MAG_W-1:0];
          step_neg = eff_str[STR_SIGN];
        end
      end
      ST_STRIDE: begin
        step_base = acc_q;
        step_mag  = mag_q;
        step_neg  = neg_q;
      end
      default: begin
      end
    endcase
  end

  ipsp_step_unit u_step (
    .base_i     (step_base),
    .page_ref_i (line_q),
    .mag_i      (step_mag),
    .neg_i      (step_neg),
    .cand_o     (cand),
    .in_page_o  (in_page)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= ST_IDLE;
      spec_q   <= 1'b0;
      pend_v_q <= 1'b0;
    end else begin
      state_q  <= state_d;
      spec_q   <= spec_d;
      pend_v_q <= pend_v_d;
    end
  end

  always_ff @(posedge clk_i) begin
    line_q      <= line_d;
    idx_q       <= idx_d;
    tag_q       <= tag_d;
    is_pf_q     <= is_pf_d;
    cls_in_q    <= cls_in_d;
    str_in_q    <= str_in_d;
    spec_in_q   <= spec_in_d;
    ent_q       <= ent_d;
    ent_valid_q <= ent_valid_d;
    acc_q       <= acc_d;
    mag_q       <= mag_d;
    neg_q       <= neg_d;
    cnt_q       <= cnt_d;
    deg_q       <= deg_d;
    pend_line_q <= pend_line_d;
    pend_meta_q <= pend_meta_d;
  end

  always_comb begin
    state_d     = state_q;
    line_d      = line_q;
    idx_d       = idx_q;
    tag_d       = tag_q;
    is_pf_d     = is_pf_q;
    cls_in_d    = cls_in_q;
    str_in_d    = str_in_q;
    spec_in_d   = spec_in_q;
    spec_d      = spec_q;
    ent_d       = ent_q;
    ent_valid_d = ent_valid_q;
    acc_d       = acc_q;
    mag_d       = mag_q;
    neg_d       = neg_q;
    cnt_d       = cnt_q;
    deg_d       = deg_q;
    pend_v_d    = pend_v_q;
    pend_line_d = pend_line_q;
    pend_meta_d = pend_meta_q;

    busy             = (state_q != ST_IDLE);
    prefetch_valid_o = 1'b0;
    last_flag_o      = 1'b0;
    tbl_req_o        = '0;
    tbl_req_o.rd_idx = access_ip_i[INDEX_BITS-1:0];
    tbl_req_o.wr_idx = idx_q;
    tbl_req_o.wr_valid = ent_valid_q;
    tbl_req_o.wr_entry = ent_q;

    case (state_q)
      ST_IDLE: begin
        if (start) begin
          tbl_req_o.rd_en = 1'b1;
          line_d    = access_addr_i[ADDR_BITS-1:LINE_OFFSET_BITS];
          idx_d     = access_ip_i[INDEX_BITS-1:0];
          tag_d     = ip_tag(access_ip_i);
          is_pf_d   = is_prefetch_i;
          cls_in_d  = meta_in_i[META_CLS_LSB +: CLS_W];
          str_in_d  = meta_in_i[STR_W-1:0];
          spec_in_d = meta_in_i[META_SPEC];
          pend_v_d  = 1'b0;
          state_d   = ST_LOOKUP;
        end
      end
      ST_LOOKUP: begin
        state_d = ST_FINISH;
        if (!hit) begin
          ent_d       = tbl_rsp_i.valid ? tbl_rsp_i.entry :
                        entry_t'{tag: tag_q, cls: cls_in_q, stride: str_in_q};
          ent_valid_d = 1'b0;
          if (in_page) begin
            pend_v_d    = 1'b1;
            pend_line_d = cand;
            pend_meta_d = '0;
          end
        end else begin
          ent_d       = '{tag: tag_q, cls: eff_cls, stride: eff_str};
          ent_valid_d = 1'b1;
          if (is_pf_q) begin
            spec_d = spec_in_q;
          end
          if (stride_ok) begin
            mag_d = eff_str[MAG_W-1:0];
            neg_d = eff_str[STR_SIGN];
            deg_d = deg_run;
            if (in_page) begin
              pend_v_d    = 1'b1;
              pend_line_d = cand;
              pend_meta_d = fill_meta(eff_cls, eff_spec);
              acc_d       = cand;
              cnt_d       = CNT_W'(1);
              if (deg_run != CNT_W'(1)) begin
                state_d = ST_STRIDE;
              end
            end else if (eff_spec) begin
              state_d = ST_NEXT;
            end
          end else if (eff_spec && in_page) begin
            pend_v_d    = 1'b1;
            pend_line_d = cand;
            pend_meta_d = fill_meta(CLS_NEXT, 1'b1);
            ent_d.cls   = CLS_SPEC;
          end
        end
      end
      ST_STRIDE: begin
        state_d = ST_FINISH;
        if (in_page) begin
          prefetch_valid_o = 1'b1;
          pend_line_d      = cand;
          acc_d            = cand;
          cnt_d            = cnt_q + CNT_W'(1);
          if ((cnt_q + CNT_W'(1)) != deg_q) begin
            state_d = ST_STRIDE;
          end
        end
      end
      ST_NEXT: begin
        state_d = ST_FINISH;
        if (in_page) begin
          pend_v_d    = 1'b1;
          pend_line_d = cand;
          pend_meta_d = fill_meta(CLS_NEXT, spec_q);
          ent_d.cls   = CLS_SPEC;
        end
      end
      ST_FINISH: begin
        tbl_req_o.wr_en  = 1'b1;
        prefetch_valid_o = pend_v_q;
        last_flag_o      = 1'b1;
        pend_v_d         = 1'b0;
        state_d          = ST_IDLE;
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  assign prefetch_addr_o = {pend_line_q, {LINE_OFFSET_BITS{1'b0}}};
  assign fill_meta_o     = pend_meta_q;

endmodule

`default_nettype wire

// File: rtl/ipsp_checker.sv
// Port-level checker for the prefetcher core, bound to the top level.
// Depends on ipsp_pkg and assert_macros.svh.
`default_nettype none
`include "assert_macros.svh"

module ipsp_checker (
  input logic                             clk_i,
  input logic                             rst_ni,
  input logic                             start,
  input logic                             busy,
  input logic                             prefetch_valid_o,
  input logic [ipsp_pkg::ADDR_BITS-1:0]   prefetch_addr_o,
  input logic [ipsp_pkg::META_W-1:0]      fill_meta_o,
  input logic                             last_flag_o
);
  import ipsp_pkg::*;

  `ASSERT_NXT(a_busy_after_accept, clk_i, rst_ni, start && !busy, busy)
  `ASSERT_IMP(a_no_result_idle, clk_i, rst_ni, !busy, !prefetch_valid_o)
  `ASSERT_NXT(a_gap_after_last, clk_i, rst_ni, prefetch_valid_o && last_flag_o, !prefetch_valid_o)
  `ASSERT_IMP(a_plain_next_single, clk_i, rst_ni, prefetch_valid_o && !fill_meta_o[0], last_flag_o)
  `ASSERT_IMP(a_line_aligned, clk_i, rst_ni, prefetch_valid_o, prefetch_addr_o[LINE_OFFSET_BITS-1:0] == '0)

endmodule

bind ip_stride_l2_prefetcher_core ipsp_checker u_checker (.*);

`default_nettype wire
